FILE: rtl/hsc_pkg.sv
// hsc_pkg: shared types and constants for the heading/speed controller.
// No dependencies.
`default_nettype none
package hsc_pkg;

    localparam int TABLE_LEN = 20;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] INV_GAIN    = 36'sd652032874;
    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [15:0] PI_Q12      = 16'sd12868;
    localparam logic signed [15:0] TWO_PI_Q12  = 16'sd25736;

    localparam logic [2:0] REG_HGAIN  = 3'd0;
    localparam logic [2:0] REG_HRGAIN = 3'd1;
    localparam logic [2:0] REG_SGAIN  = 3'd2;
    localparam logic [2:0] REG_SLIM   = 3'd3;
    localparam logic [2:0] REG_ARAD   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_ATAN,
        ST_WRAP,
        ST_COS,
        ST_POW,
        ST_GAIN,
        ST_SPEED,
        ST_TURN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic atan_step;
        logic wrap;
        logic cos_step;
        logic pow_step;
        logic gain;
        logic speed;
        logic turn;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic atan_done;
        logic cos_done;
        logic pow_done;
        logic out_full;
    } status_t;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 36'sd843314857;
            5'd1:  atan_q30 = 36'sd497837829;
            5'd2:  atan_q30 = 36'sd263043837;
            5'd3:  atan_q30 = 36'sd133525159;
            5'd4:  atan_q30 = 36'sd67021687;
            5'd5:  atan_q30 = 36'sd33543516;
            5'd6:  atan_q30 = 36'sd16775851;
            5'd7:  atan_q30 = 36'sd8388437;
            5'd8:  atan_q30 = 36'sd4194283;
            5'd9:  atan_q30 = 36'sd2097149;
            5'd10: atan_q30 = 36'sd1048576;
            5'd11: atan_q30 = 36'sd524288;
            5'd12: atan_q30 = 36'sd262144;
            5'd13: atan_q30 = 36'sd131072;
            5'd14: atan_q30 = 36'sd65536;
            5'd15: atan_q30 = 36'sd32768;
            5'd16: atan_q30 = 36'sd16384;
            5'd17: atan_q30 = 36'sd8192;
            5'd18: atan_q30 = 36'sd4096;
            5'd19: atan_q30 = 36'sd2048;
            default: atan_q30 = 36'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: rtl/hsc_if.sv
// hsc_if: valid/ready channel interfaces for pose input, results and config.
// No dependencies.
`default_nettype none
interface hsc_in_if (input wire logic clk);
    logic               valid;
    logic               ready;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [14:0] heading;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    modport source (output valid, pose_x, pose_y, heading, goal_x, goal_y, input ready);
    modport sink (input valid, pose_x, pose_y, heading, goal_x, goal_y, output ready);
endinterface

interface hsc_out_if (input wire logic clk);
    logic               valid;
    logic               ready;
    logic signed [15:0] forward_speed;
    logic signed [15:0] turn_rate;
    logic signed [14:0] heading_error;
    logic        [15:0] goal_distance;
    logic               arrived;
    modport source (output valid, forward_speed, turn_rate, heading_error, goal_distance,
                    arrived, input ready);
    modport sink (input valid, forward_speed, turn_rate, heading_error, goal_distance,
                  arrived, output ready);
endinterface

interface hsc_cfg_if (input wire logic clk);
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/hsc_ctrl.sv
// hsc_ctrl: sequencing state machine for the controller.
// Depends on hsc_pkg.
`default_nettype none
module hsc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire hsc_pkg::status_t  status,
    output hsc_pkg::cmd_t          cmd,
    output logic                   in_ready
);
    hsc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hsc_pkg::ST_IDLE:  if (in_fire) state_next = hsc_pkg::ST_SQRT;
            hsc_pkg::ST_SQRT:  if (status.sqrt_done) state_next = hsc_pkg::ST_ATAN;
            hsc_pkg::ST_ATAN:  if (status.atan_done) state_next = hsc_pkg::ST_WRAP;
            hsc_pkg::ST_WRAP:  state_next = hsc_pkg::ST_COS;
            hsc_pkg::ST_COS:   if (status.cos_done) state_next = hsc_pkg::ST_POW;
            hsc_pkg::ST_POW:   if (status.pow_done) state_next = hsc_pkg::ST_GAIN;
            hsc_pkg::ST_GAIN:  state_next = hsc_pkg::ST_SPEED;
            hsc_pkg::ST_SPEED: state_next = hsc_pkg::ST_TURN;
            hsc_pkg::ST_TURN:  state_next = hsc_pkg::ST_OUT;
            hsc_pkg::ST_OUT:   if (!status.out_full) state_next = hsc_pkg::ST_IDLE;
            default:           state_next = hsc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            hsc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            hsc_pkg::ST_SQRT:  cmd.sqrt_step = 1'b1;
            hsc_pkg::ST_ATAN:  cmd.atan_step = 1'b1;
            hsc_pkg::ST_WRAP:  cmd.wrap = 1'b1;
            hsc_pkg::ST_COS:   cmd.cos_step = 1'b1;
            hsc_pkg::ST_POW:   cmd.pow_step = 1'b1;
            hsc_pkg::ST_GAIN:  cmd.gain = 1'b1;
            hsc_pkg::ST_SPEED: cmd.speed = 1'b1;
            hsc_pkg::ST_TURN:  cmd.turn = 1'b1;
            hsc_pkg::ST_OUT:   cmd.out_load = !status.out_full;
            default:           cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/hsc_dp.sv
// hsc_dp: datapath with shared CORDIC, bit-serial square root, power loop and
// output register. Depends on hsc_pkg and hsc_if.
`default_nettype none
module hsc_dp #(
    parameter int COS_POWER    = 13,
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hsc_pkg::cmd_t    cmd,
    output hsc_pkg::status_t      status,
    hsc_in_if.sink                in_ch,
    hsc_out_if.source             out_ch,
    hsc_cfg_if.sink               cfg
);
    localparam int NSTEPS = (CORDIC_STEPS > hsc_pkg::TABLE_LEN) ? hsc_pkg::TABLE_LEN
                                                                : CORDIC_STEPS;

    logic [15:0] hgain_reg, hrgain_reg, sgain_reg;
    logic [14:0] slim_reg, arad_reg;
    logic signed [15:0] last_err_reg;

    logic signed [16:0] dx_reg, dy_reg;
    logic signed [14:0] hd_reg;
    logic [17:0] root_reg;
    logic [17:0] sr_rem_reg;
    logic [4:0]  cnt_reg;
    logic signed [35:0] x_reg, y_reg, z_reg;
    logic        neg_reg;
    logic signed [15:0] err_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] t_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] turn_reg;
    logic               out_valid_reg;
    logic signed [15:0] o_speed_reg, o_turn_reg;
    logic signed [14:0] o_err_reg;
    logic        [15:0] o_dist_reg;
    logic               o_arr_reg;

    // Square root of 4*(dx^2 + dy^2): 18 result bits, one per cycle
    logic signed [33:0] dx_w, dy_w;
    logic [33:0] dsq;
    logic [35:0] rad;
    logic [5:0]  shpos;
    logic [1:0]  pair;
    logic [19:0] sr_cand;
    logic [19:0] sr_trial;
    logic [16:0] dist_full;
    logic [15:0] dsat;
    assign dx_w      = 34'(dx_reg);
    assign dy_w      = 34'(dy_reg);
    assign dsq       = dx_w * dx_w + dy_w * dy_w;
    assign rad       = {dsq, 2'b00};
    assign shpos     = 6'd34 - {cnt_reg, 1'b0};
    assign pair      = 2'(rad >> shpos);
    assign sr_cand   = {sr_rem_reg, pair};
    assign sr_trial  = {root_reg, 2'b01};
    assign dist_full = 17'((root_reg + 18'd1) >> 1);
    assign dsat      = dist_full[16] ? 16'hFFFF : dist_full[15:0];

    // CORDIC shifted operands
    logic signed [35:0] xs, ys, atv;
    assign xs  = x_reg >>> cnt_reg;
    assign ys  = y_reg >>> cnt_reg;
    assign atv = hsc_pkg::atan_q30(cnt_reg);

    logic signed [35:0] zr;
    logic signed [17:0] bear;
    assign zr   = (z_reg + 36'sd131072) >>> 18;
    assign bear = (zr > 36'(hsc_pkg::PI_Q12)) ? 18'(hsc_pkg::PI_Q12) :
                  (zr < -36'(hsc_pkg::PI_Q12)) ? -18'(hsc_pkg::PI_Q12) : 18'(zr);

    logic signed [18:0] raw_err;
    assign raw_err = 19'(bear) - 19'(hd_reg);

    // 32x32 multiplier for the power loop
    logic signed [63:0] pmul;
    assign pmul = p_reg * c_reg;
    logic signed [33:0] pnext;
    assign pnext = 34'((pmul + 64'sd536870912) >>> 30);

    logic signed [48:0] gmul;
    assign gmul = p_reg * $signed({1'b0, sgain_reg});
    logic signed [49:0] smul;
    assign smul = t_reg * $signed({1'b0, dist_full});
    logic signed [49:0] sr;
    assign sr = (smul + 50'sd128) >>> 8;
    logic signed [16:0] slim_s;
    assign slim_s = $signed({2'b00, slim_reg});

    logic signed [16:0] ediff;
    assign ediff = 17'(err_reg) - 17'(last_err_reg);
    logic signed [35:0] turn_acc;
    assign turn_acc = 36'($signed({1'b0, hgain_reg}) * err_reg)
                    + 36'($signed({1'b0, hrgain_reg}) * ediff);
    logic signed [35:0] turn_r;
    assign turn_r = (turn_acc + 36'sd2048) >>> 12;

    assign status = '{sqrt_done: (cnt_reg == 5'd17),
                      atan_done: (cnt_reg == 5'(NSTEPS - 1)),
                      cos_done:  (cnt_reg == 5'(NSTEPS - 1)),
                      pow_done:  (cnt_reg == 5'(COS_POWER - 1)),
                      out_full:  (out_valid_reg && !out_ch.ready)};

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hgain_reg     <= 16'd4096;
            hrgain_reg    <= 16'd2048;
            sgain_reg     <= 16'd4096;
            slim_reg      <= 15'd4096;
            arad_reg      <= 15'd20;
            last_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    hsc_pkg::REG_HGAIN:  hgain_reg  <= cfg.data;
                    hsc_pkg::REG_HRGAIN: hrgain_reg <= cfg.data;
                    hsc_pkg::REG_SGAIN:  sgain_reg  <= cfg.data;
                    hsc_pkg::REG_SLIM:   slim_reg   <= cfg.data[14:0];
                    hsc_pkg::REG_ARAD:   arad_reg   <= cfg.data[14:0];
                    default: ;
                endcase
            end
            if (cmd.turn)
                last_err_reg <= err_reg;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg     <= 17'(in_ch.goal_x) - 17'(in_ch.pose_x);
            dy_reg     <= 17'(in_ch.goal_y) - 17'(in_ch.pose_y);
            hd_reg     <= in_ch.heading;
            cnt_reg    <= '0;
            root_reg   <= '0;
            sr_rem_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            if (sr_cand >= sr_trial)
            begin
                sr_rem_reg <= 18'(sr_cand - sr_trial);
                root_reg   <= {root_reg[16:0], 1'b1};
            end
            else
            begin
                sr_rem_reg <= sr_cand[17:0];
                root_reg   <= {root_reg[16:0], 1'b0};
            end
            if (cnt_reg == 5'd17)
            begin
                cnt_reg <= '0;
                // atan prerotation
                if (dx_reg < 0)
                begin
                    if (dy_reg >= 0)
                    begin
                        x_reg <= 36'(dy_reg) <<< 8;
                        y_reg <= -(36'(dx_reg) <<< 8);
                        z_reg <= hsc_pkg::HALF_PI_Q30;
                    end
                    else
                    begin
                        x_reg <= -(36'(dy_reg) <<< 8);
                        y_reg <= 36'(dx_reg) <<< 8;
                        z_reg <= -hsc_pkg::HALF_PI_Q30;
                    end
                end
                else
                begin
                    x_reg <= 36'(dx_reg) <<< 8;
                    y_reg <= 36'(dy_reg) <<< 8;
                    z_reg <= '0;
                end
            end
            else
                cnt_reg <= cnt_reg + 5'd1;
        end
        if (cmd.atan_step)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atv;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atv;
            end
            cnt_reg <= (cnt_reg == 5'(NSTEPS - 1)) ? 5'd0 : cnt_reg + 5'd1;
        end
        if (cmd.wrap)
        begin : wrap_blk
            logic signed [18:0] e;
            logic signed [35:0] za;
            logic               ng;
            e = (dx_reg == 0 && dy_reg == 0) ? -19'(hd_reg) : raw_err;
            if (e > 19'(hsc_pkg::PI_Q12))
                e = e - 19'(hsc_pkg::TWO_PI_Q12);
            else if (e < -19'(hsc_pkg::PI_Q12))
                e = e + 19'(hsc_pkg::TWO_PI_Q12);
            za = 36'(e) <<< 18;
            ng = 1'b0;
            if (za > hsc_pkg::HALF_PI_Q30)
            begin
                za = za - hsc_pkg::PI_Q30;
                ng = 1'b1;
            end
            else if (za < -hsc_pkg::HALF_PI_Q30)
            begin
                za = za + hsc_pkg::PI_Q30;
                ng = 1'b1;
            end
            err_reg <= 16'(e);
            neg_reg <= ng;
            z_reg   <= za;
            x_reg   <= hsc_pkg::INV_GAIN;
            y_reg   <= '0;
            cnt_reg <= '0;
        end
        if (cmd.cos_step)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atv;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atv;
            end
            cnt_reg <= (cnt_reg == 5'(NSTEPS - 1)) ? 5'd0 : cnt_reg + 5'd1;
            if (cnt_reg == 5'(NSTEPS - 1))
            begin : cfin
                logic signed [35:0] xf;
                xf = (z_reg >= 0) ? x_reg - ys : x_reg + ys;
                if (neg_reg)
                    xf = -xf;
                if (xf > hsc_pkg::ONE_Q30)
                    xf = hsc_pkg::ONE_Q30;
                else if (xf < -hsc_pkg::ONE_Q30)
                    xf = -hsc_pkg::ONE_Q30;
                c_reg <= 32'(xf);
                p_reg <= 32'(hsc_pkg::ONE_Q30);
            end
        end
        if (cmd.pow_step)
        begin
            p_reg   <= 32'(pnext);
            cnt_reg <= (cnt_reg == 5'(COS_POWER - 1)) ? 5'd0 : cnt_reg + 5'd1;
        end
        if (cmd.gain)
            t_reg <= 32'((gmul + 49'sd536870912) >>> 30);
        if (cmd.speed)
        begin
            if (sr > 50'(slim_s))
                speed_reg <= 16'(slim_s);
            else if (sr < -50'(slim_s))
                speed_reg <= 16'(-slim_s);
            else
                speed_reg <= 16'(sr);
        end
        if (cmd.turn)
            turn_reg <= (turn_r > 36'sd32767) ? 16'sh7FFF :
                        (turn_r < -36'sd32768) ? 16'sh8000 : 16'(turn_r);
        if (cmd.out_load)
        begin
            o_speed_reg <= speed_reg;
            o_turn_reg  <= turn_reg;
            o_err_reg   <= 15'(err_reg);
            o_dist_reg  <= dsat;
            o_arr_reg   <= (dsat < {1'b0, arad_reg});
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.forward_speed = o_speed_reg;
    assign out_ch.turn_rate     = o_turn_reg;
    assign out_ch.heading_error = o_err_reg;
    assign out_ch.goal_distance = o_dist_reg;
    assign out_ch.arrived       = o_arr_reg;
endmodule
`default_nettype wire

FILE: rtl/heading_speed_controller_unit.sv
// heading_speed_controller_unit: top level, controller plus datapath.
// Depends on hsc_pkg, hsc_if, hsc_ctrl, hsc_dp.
//
// Channels: pose/goal input, result output, config write (always ready).
// One transaction in gives one result out. Each result passes in turn through
// the bit-serial square root, the shared CORDIC and the power multiply loop.
// One item is in flight at a time; input ready is high only when idle, in the
// cycle after the result is loaded, so no new transaction is accepted before
// the previous result is loaded.
// The output register holds a result until taken; a stalled receiver holds
// the block in its final state. Reset restores default gains and clears
// the previous heading error and output valid.
`default_nettype none
module heading_speed_controller_unit #(
    parameter int COS_POWER    = 13,
    parameter int CORDIC_STEPS = 14
) (
    input wire logic  clk,
    input wire logic  rst_n,
    hsc_in_if.sink    in_ch,
    hsc_out_if.source out_ch,
    hsc_cfg_if.sink   cfg
);
    hsc_pkg::cmd_t    cmd;
    hsc_pkg::status_t status;
    logic             rdy;

    assign in_ch.ready = rdy;

    hsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_ch.valid && rdy),
        .status   (status),
        .cmd      (cmd),
        .in_ready (rdy)
    );

    hsc_dp #(.COS_POWER(COS_POWER), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );
endmodule
`default_nettype wire

FILE: rtl/hsc_checker.sv
// hsc_checker: port-level assertions, bound to the top level.
// Depends on heading_speed_controller_unit ports.
`default_nettype none
module hsc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] goal_dist,
    input wire logic        arr
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(goal_dist) && $stable(arr))
        else $error("result changed while stalled");
    a_arr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && goal_dist == 16'hFFFF |-> !arr) else $error("arrived at max range");
endmodule

bind heading_speed_controller_unit hsc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .goal_dist (out_ch.goal_distance),
    .arr       (out_ch.arrived)
);
`default_nettype wire
